// File: hdl/qla_pkg.sv
// qla_pkg: shared types, constants and rounding helper for the look-at quaternion block.
// Used by every module under hdl but qla_delay; depends on nothing.
`default_nettype none
package qla_pkg;

  localparam int COMPONENT_BITS = 24;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int QUAT_BITS      = QUAT_FRAC_BITS + 2;

  // Working format is Q.30 throughout.
  localparam int WORK_FRAC  = 30;
  localparam int VEC_N      = 4;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  // abs/leading one, shift, square, sum, root steps, divide setup, divide steps, sign
  localparam int UNIT_LAT   = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  localparam logic signed [67:0] ONE_W      = 68'sd1 <<< WORK_FRAC;
  localparam logic signed [67:0] OPP_LIMIT  = -68'sd999 * ONE_W;
  localparam logic signed [67:0] AXIS_LIMIT = 68'((68'd1 << 60) / 100);
  localparam logic signed [67:0] QUAT_LIM   = 68'sd1 <<< QUAT_FRAC_BITS;
  localparam logic signed [QUAT_BITS-1:0] QUAT_ONE = QUAT_BITS'(QUAT_LIM);

  typedef logic signed [31:0] wv_t;
  typedef logic signed [33:0] ui_t;
  typedef wv_t [VEC_N-1:0] wvec_t;
  typedef ui_t [VEC_N-1:0] uvec_t;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] dir_x;
    logic signed [COMPONENT_BITS-1:0] dir_y;
    logic signed [COMPONENT_BITS-1:0] dir_z;
    logic signed [COMPONENT_BITS-1:0] up_x;
    logic signed [COMPONENT_BITS-1:0] up_y;
    logic signed [COMPONENT_BITS-1:0] up_z;
  } qla_in_t;

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] quat_w;
    logic signed [QUAT_BITS-1:0] quat_x;
    logic signed [QUAT_BITS-1:0] quat_y;
    logic signed [QUAT_BITS-1:0] quat_z;
    logic                        degenerate;
  } qla_out_t;

  // Divide by 2^s, round half away from zero.
  function automatic logic signed [67:0] rsh(input logic signed [67:0] x, input int s);
    logic signed [67:0] h;
    logic signed [67:0] nb;
    h  = 68'sd1 <<< (s - 1);
    nb = x[67] ? 68'sd1 : 68'sd0;
    rsh = (x + h - nb) >>> s;
  endfunction

endpackage
`default_nettype wire

// File: hdl/qla_delay.sv
// qla_delay: enabled shift line that aligns side data with the pipeline.
// Depends on nothing.
`default_nettype none
module qla_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < D; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[D-1];

endmodule
`default_nettype wire

// File: hdl/qla_unit.sv
// qla_unit: pipelined vector normalizer (scale, root of square sum, per-lane restoring divide).
// Depends on qla_pkg; advances only while en is high.
`default_nettype none
module qla_unit (
  input  logic          clk,
  input  logic          en,
  input  qla_pkg::uvec_t vec_in,
  output qla_pkg::wvec_t vec_out
);

  localparam int N  = qla_pkg::VEC_N;
  localparam int SS = qla_pkg::SQRT_STEPS;
  localparam int DS = qla_pkg::DIV_STEPS;

  // stage 1: magnitudes and leading one of the largest
  logic [33:0]  mag_c [N];
  logic [N-1:0] neg_c;
  logic [33:0]  or_c;
  logic [5:0]   pos_c;

  always_comb begin
    or_c = '0;
    for (int i = 0; i < N; i++) begin
      neg_c[i] = vec_in[i][33];
      mag_c[i] = neg_c[i] ? (~vec_in[i] + 34'd1) : vec_in[i];
      or_c     = or_c | mag_c[i];
    end
    pos_c = '0;
    for (int b = 0; b < 34; b++) begin
      if (or_c[b]) pos_c = 6'(b);
    end
  end

  logic [33:0]  mag1_r [N];
  logic [N-1:0] neg1_r;
  logic [5:0]   pos1_r;
  logic         zero1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) mag1_r[i] <= mag_c[i];
      neg1_r  <= neg_c;
      pos1_r  <= pos_c;
      zero1_r <= (or_c == '0);
    end
  end

  // stage 2: bring the largest into [2^30, 2^31), dropping low bits
  logic [30:0]  mn_c  [N];
  logic [30:0]  mn2_r [N];
  logic [N-1:0] neg2_r;
  logic         zero2_r;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (pos1_r > 6'd30) mn_c[i] = 31'(mag1_r[i] >> (pos1_r - 6'd30));
      else                mn_c[i] = 31'(mag1_r[i] << (6'd30 - pos1_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) mn2_r[i] <= mn_c[i];
      neg2_r  <= neg1_r;
      zero2_r <= zero1_r;
    end
  end

  // stage 3 squares, stage 4 sum
  logic [61:0]  sq3_r [N];
  logic [30:0]  mn3_r [N];
  logic [N-1:0] neg3_r;
  logic         zero3_r;
  logic [63:0]  sum4_r;
  logic [30:0]  mn4_r [N];
  logic [N-1:0] neg4_r;
  logic         zero4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        sq3_r[i] <= mn2_r[i] * mn2_r[i];
        mn3_r[i] <= mn2_r[i];
        mn4_r[i] <= mn3_r[i];
      end
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
      sum4_r  <= 64'(sq3_r[0]) + 64'(sq3_r[1]) + 64'(sq3_r[2]) + 64'(sq3_r[3]);
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
    end
  end

  // root: one result bit per stage
  logic [63:0]  sx_in    [SS];
  logic [33:0]  srem_in  [SS];
  logic [31:0]  sroot_in [SS];
  logic [35:0]  sr_c     [SS];
  logic [35:0]  st_c     [SS];
  logic [SS-1:0] sge_c;
  logic [63:0]  sx_r     [SS];
  logic [33:0]  srem_r   [SS];
  logic [31:0]  sroot_r  [SS];
  logic [30:0]  smn_r    [SS][N];
  logic [N-1:0] sneg_r   [SS];
  logic         szero_r  [SS];

  always_comb begin
    sx_in[0]    = sum4_r;
    srem_in[0]  = '0;
    sroot_in[0] = '0;
    for (int j = 1; j < SS; j++) begin
      sx_in[j]    = sx_r[j-1];
      srem_in[j]  = srem_r[j-1];
      sroot_in[j] = sroot_r[j-1];
    end
    for (int j = 0; j < SS; j++) begin
      sr_c[j]  = {srem_in[j], sx_in[j][63:62]};
      st_c[j]  = {2'b00, sroot_in[j], 2'b01};
      sge_c[j] = (sr_c[j] >= st_c[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < SS; j++) begin
        sx_r[j]    <= {sx_in[j][61:0], 2'b00};
        srem_r[j]  <= sge_c[j] ? 34'(sr_c[j] - st_c[j]) : sr_c[j][33:0];
        sroot_r[j] <= {sroot_in[j][30:0], sge_c[j]};
      end
      smn_r[0]   <= mn4_r;
      sneg_r[0]  <= neg4_r;
      szero_r[0] <= zero4_r;
      for (int j = 1; j < SS; j++) begin
        smn_r[j]   <= smn_r[j-1];
        sneg_r[j]  <= sneg_r[j-1];
        szero_r[j] <= szero_r[j-1];
      end
    end
  end

  // divide: q = (m * 2^30 + L/2) / L, one quotient bit per stage
  logic [31:0]  len_c;
  logic [61:0]  num_c  [N];
  logic [31:0]  drem_r [DS+1][N];
  logic [30:0]  dnb_r  [DS+1][N];
  logic [30:0]  dq_r   [DS+1][N];
  logic [31:0]  dl_r   [DS+1];
  logic [N-1:0] dneg_r [DS+1];
  logic         dzero_r[DS+1];
  logic [32:0]  dr_c   [DS][N];
  logic         dge_c  [DS][N];

  assign len_c = sroot_r[SS-1];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      num_c[i] = 62'({smn_r[SS-1][i], 30'd0}) + 62'(len_c >> 1);
    end
    for (int j = 0; j < DS; j++) begin
      for (int i = 0; i < N; i++) begin
        dr_c[j][i]  = {drem_r[j][i], dnb_r[j][i][30]};
        dge_c[j][i] = (dr_c[j][i] >= {1'b0, dl_r[j]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        drem_r[0][i] <= {1'b0, num_c[i][61:31]};
        dnb_r[0][i]  <= num_c[i][30:0];
        dq_r[0][i]   <= '0;
      end
      dl_r[0]    <= len_c;
      dneg_r[0]  <= sneg_r[SS-1];
      dzero_r[0] <= szero_r[SS-1];
      for (int j = 0; j < DS; j++) begin
        for (int i = 0; i < N; i++) begin
          drem_r[j+1][i] <= dge_c[j][i] ? 32'(dr_c[j][i] - {1'b0, dl_r[j]})
                                        : dr_c[j][i][31:0];
          dnb_r[j+1][i]  <= {dnb_r[j][i][29:0], 1'b0};
          dq_r[j+1][i]   <= {dq_r[j][i][29:0], dge_c[j][i]};
        end
        dl_r[j+1]    <= dl_r[j];
        dneg_r[j+1]  <= dneg_r[j];
        dzero_r[j+1] <= dzero_r[j];
      end
    end
  end

  // restore sign; a zero vector stays zero
  qla_pkg::wvec_t out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        if (dzero_r[DS])        out_r[i] <= '0;
        else if (dneg_r[DS][i]) out_r[i] <= -$signed({1'b0, dq_r[DS][i]});
        else                    out_r[i] <= $signed({1'b0, dq_r[DS][i]});
      end
    end
  end

  assign vec_out = out_r;

endmodule
`default_nettype wire

// File: hdl/quaternion_look_at_top.sv
// quaternion_look_at_top: look-at orientation quaternion, Q1.14 out, fully pipelined.
// Throughput one beat per cycle unless a held result stalls the pipe; each beat passes
// through four chained normalizer units (32 root steps and 31 divide steps in each).
// A stall on a valid result freezes the whole pipe; in_stall follows it in the same cycle.
// Synchronous active-low reset clears only the valid bits; data registers are not reset.
// Depends on qla_pkg, qla_unit and qla_delay.
`default_nettype none
module quaternion_look_at_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qla_pkg::qla_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output qla_pkg::qla_out_t out_data
);

  localparam int UL   = qla_pkg::UNIT_LAT;
  localparam int CB   = qla_pkg::COMPONENT_BITS;
  localparam int QB   = qla_pkg::QUAT_BITS;
  localparam int WF   = qla_pkg::WORK_FRAC;
  // pipeline positions, counted in register stages after the input register
  localparam int TA   = UL;            // unit(d), unit(u)
  localparam int TB   = TA + 4 + UL;   // first rotation, unit(up')
  localparam int TC   = TB + 2 + UL;   // unit(newUp)
  localparam int TD   = TC + 3 + UL;   // second rotation
  localparam int LAST = TD + 3;        // result register
  localparam int WV   = $bits(qla_pkg::wvec_t);

  localparam qla_pkg::ui_t ONE_U = 34'(qla_pkg::ONE_W);

  // Advance everything unless a finished beat is held at the output.
  logic adv;
  logic [LAST:0] vld_r;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  // Input register.
  qla_pkg::qla_in_t in_q_r;

  always_ff @(posedge clk) begin
    if (adv) in_q_r <= in_data;
  end

  // Exact parallel test on the raw components: cross product is zero.
  logic signed [2*CB-1:0] pd_r [6];
  logic raw_deg_r;
  logic raw_deg_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      pd_r[0]   <= in_q_r.dir_y * in_q_r.up_z;
      pd_r[1]   <= in_q_r.dir_z * in_q_r.up_y;
      pd_r[2]   <= in_q_r.dir_z * in_q_r.up_x;
      pd_r[3]   <= in_q_r.dir_x * in_q_r.up_z;
      pd_r[4]   <= in_q_r.dir_x * in_q_r.up_y;
      pd_r[5]   <= in_q_r.dir_y * in_q_r.up_x;
      raw_deg_r <= (pd_r[0] == pd_r[1]) && (pd_r[2] == pd_r[3]) && (pd_r[4] == pd_r[5]);
    end
  end

  qla_delay #(.W(1), .D(TA + 1)) u_raw_dly (
    .clk(clk), .en(adv), .d(raw_deg_r), .q(raw_deg_d)
  );

  // Unit direction n and unit up v.
  qla_pkg::uvec_t dvec_c, uvec_c;
  qla_pkg::wvec_t n_w, v_w;

  always_comb begin
    dvec_c[0] = 34'(in_q_r.dir_x);
    dvec_c[1] = 34'(in_q_r.dir_y);
    dvec_c[2] = 34'(in_q_r.dir_z);
    dvec_c[3] = '0;
    uvec_c[0] = 34'(in_q_r.up_x);
    uvec_c[1] = 34'(in_q_r.up_y);
    uvec_c[2] = 34'(in_q_r.up_z);
    uvec_c[3] = '0;
  end

  qla_unit u_unit_dir (.clk(clk), .en(adv), .vec_in(dvec_c), .vec_out(n_w));
  qla_unit u_unit_up  (.clk(clk), .en(adv), .vec_in(uvec_c), .vec_out(v_w));

  // rt = n x v, then up' = rt x n, each rounded back to Q.30.
  logic signed [63:0] x1p_r [6];
  qla_pkg::ui_t       rt_r  [3];
  logic signed [65:0] x3p_r [6];
  qla_pkg::wvec_t     n_d2;
  qla_pkg::uvec_t     up_r;
  qla_pkg::ui_t       up_c  [3];
  logic               deg4_r;

  qla_delay #(.W(WV), .D(2)) u_n_dly (.clk(clk), .en(adv), .d(n_w), .q(n_d2));

  always_comb begin
    up_c[0] = 34'(qla_pkg::rsh(68'(x3p_r[0]) - 68'(x3p_r[1]), WF));
    up_c[1] = 34'(qla_pkg::rsh(68'(x3p_r[2]) - 68'(x3p_r[3]), WF));
    up_c[2] = 34'(qla_pkg::rsh(68'(x3p_r[4]) - 68'(x3p_r[5]), WF));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1p_r[0] <= $signed(n_w[1]) * $signed(v_w[2]);
      x1p_r[1] <= $signed(n_w[2]) * $signed(v_w[1]);
      x1p_r[2] <= $signed(n_w[2]) * $signed(v_w[0]);
      x1p_r[3] <= $signed(n_w[0]) * $signed(v_w[2]);
      x1p_r[4] <= $signed(n_w[0]) * $signed(v_w[1]);
      x1p_r[5] <= $signed(n_w[1]) * $signed(v_w[0]);
      rt_r[0]  <= 34'(qla_pkg::rsh(68'(x1p_r[0]) - 68'(x1p_r[1]), WF));
      rt_r[1]  <= 34'(qla_pkg::rsh(68'(x1p_r[2]) - 68'(x1p_r[3]), WF));
      rt_r[2]  <= 34'(qla_pkg::rsh(68'(x1p_r[4]) - 68'(x1p_r[5]), WF));
      x3p_r[0] <= rt_r[1] * $signed(n_d2[2]);
      x3p_r[1] <= rt_r[2] * $signed(n_d2[1]);
      x3p_r[2] <= rt_r[2] * $signed(n_d2[0]);
      x3p_r[3] <= rt_r[0] * $signed(n_d2[2]);
      x3p_r[4] <= rt_r[0] * $signed(n_d2[1]);
      x3p_r[5] <= rt_r[1] * $signed(n_d2[0]);
      up_r[0]  <= up_c[0];
      up_r[1]  <= up_c[1];
      up_r[2]  <= up_c[2];
      up_r[3]  <= '0;
      // Flag identity when parallel exactly, or when up' rounds away to nothing.
      deg4_r   <= raw_deg_d || ((up_c[0] == '0) && (up_c[1] == '0) && (up_c[2] == '0));
    end
  end

  // Rotation from +Z onto n: (1 + nz, -ny, nx, 0), or a half turn about -Y when n points
  // almost straight down -Z.
  qla_pkg::uvec_t t1_r, t1_d;
  logic opp1_c;

  assign opp1_c = (68'($signed(n_w[2])) * 68'sd1000) < qla_pkg::OPP_LIMIT;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (opp1_c) begin
        t1_r[0] <= '0;
        t1_r[1] <= '0;
        t1_r[2] <= -ONE_U;
        t1_r[3] <= '0;
      end else begin
        t1_r[0] <= ONE_U + 34'($signed(n_w[2]));
        t1_r[1] <= -34'($signed(n_w[1]));
        t1_r[2] <= 34'($signed(n_w[0]));
        t1_r[3] <= '0;
      end
    end
  end

  qla_delay #(.W($bits(qla_pkg::uvec_t)), .D(3)) u_t1_dly (
    .clk(clk), .en(adv), .d(t1_r), .q(t1_d)
  );

  qla_pkg::wvec_t r1_w, b2_w;

  qla_unit u_unit_rot1 (.clk(clk), .en(adv), .vec_in(t1_d), .vec_out(r1_w));
  qla_unit u_unit_upp  (.clk(clk), .en(adv), .vec_in(up_r), .vec_out(b2_w));

  // newUp = +Y rotated by r1.
  logic signed [63:0] yp_r [6];
  qla_pkg::uvec_t     nu_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      yp_r[0] <= $signed(r1_w[1]) * $signed(r1_w[2]);
      yp_r[1] <= $signed(r1_w[0]) * $signed(r1_w[3]);
      yp_r[2] <= $signed(r1_w[1]) * $signed(r1_w[1]);
      yp_r[3] <= $signed(r1_w[3]) * $signed(r1_w[3]);
      yp_r[4] <= $signed(r1_w[2]) * $signed(r1_w[3]);
      yp_r[5] <= $signed(r1_w[0]) * $signed(r1_w[1]);
      nu_r[0] <= 34'(qla_pkg::rsh(68'(yp_r[0]) - 68'(yp_r[1]), WF - 1));
      nu_r[1] <= ONE_U - 34'(qla_pkg::rsh(68'(yp_r[2]) + 68'(yp_r[3]), WF - 1));
      nu_r[2] <= 34'(qla_pkg::rsh(68'(yp_r[4]) + 68'(yp_r[5]), WF - 1));
      nu_r[3] <= '0;
    end
  end

  qla_pkg::wvec_t a2_w, b2_d, r1_d;

  qla_unit u_unit_nu (.clk(clk), .en(adv), .vec_in(nu_r), .vec_out(a2_w));

  qla_delay #(.W(WV), .D(2 + UL)) u_b2_dly (.clk(clk), .en(adv), .d(b2_w), .q(b2_d));
  qla_delay #(.W(WV), .D(TD - TB)) u_r1_dly (.clk(clk), .en(adv), .d(r1_w), .q(r1_d));

  // Rotation from newUp (a) onto up' (b).
  logic signed [63:0] zp_r [11];
  qla_pkg::wvec_t     a_d1_r;
  qla_pkg::ui_t       c2_r;
  qla_pkg::ui_t       t2_r [3];
  qla_pkg::uvec_t     axis_r;
  qla_pkg::uvec_t     t2v_r;
  logic               axsmall_c;
  logic               opp2_c;

  assign axsmall_c = (68'(zp_r[9]) + 68'(zp_r[10])) < qla_pkg::AXIS_LIMIT;
  assign opp2_c    = (68'(c2_r) * 68'sd1000) < qla_pkg::OPP_LIMIT;

  always_ff @(posedge clk) begin
    if (adv) begin
      zp_r[0]  <= $signed(a2_w[0]) * $signed(b2_d[0]);
      zp_r[1]  <= $signed(a2_w[1]) * $signed(b2_d[1]);
      zp_r[2]  <= $signed(a2_w[2]) * $signed(b2_d[2]);
      zp_r[3]  <= $signed(a2_w[1]) * $signed(b2_d[2]);
      zp_r[4]  <= $signed(a2_w[2]) * $signed(b2_d[1]);
      zp_r[5]  <= $signed(a2_w[2]) * $signed(b2_d[0]);
      zp_r[6]  <= $signed(a2_w[0]) * $signed(b2_d[2]);
      zp_r[7]  <= $signed(a2_w[0]) * $signed(b2_d[1]);
      zp_r[8]  <= $signed(a2_w[1]) * $signed(b2_d[0]);
      zp_r[9]  <= $signed(a2_w[1]) * $signed(a2_w[1]);
      zp_r[10] <= $signed(a2_w[0]) * $signed(a2_w[0]);
      a_d1_r   <= a2_w;

      c2_r    <= 34'(qla_pkg::rsh(68'(zp_r[0]) + 68'(zp_r[1]) + 68'(zp_r[2]), WF));
      t2_r[0] <= 34'(qla_pkg::rsh(68'(zp_r[3]) - 68'(zp_r[4]), WF));
      t2_r[1] <= 34'(qla_pkg::rsh(68'(zp_r[5]) - 68'(zp_r[6]), WF));
      t2_r[2] <= 34'(qla_pkg::rsh(68'(zp_r[7]) - 68'(zp_r[8]), WF));
      // Half-turn axis: Z x a, or X x a when a lies close to Z.
      axis_r[0] <= '0;
      axis_r[3] <= axsmall_c ? 34'($signed(a_d1_r[1])) : '0;
      axis_r[2] <= axsmall_c ? -34'($signed(a_d1_r[2])) : 34'($signed(a_d1_r[0]));
      axis_r[1] <= axsmall_c ? '0 : -34'($signed(a_d1_r[1]));

      if (opp2_c) begin
        t2v_r <= axis_r;
      end else begin
        t2v_r[0] <= ONE_U + c2_r;
        t2v_r[1] <= t2_r[0];
        t2v_r[2] <= t2_r[1];
        t2v_r[3] <= t2_r[2];
      end
    end
  end

  qla_pkg::wvec_t r2_w;

  qla_unit u_unit_rot2 (.clk(clk), .en(adv), .vec_in(t2v_r), .vec_out(r2_w));

  // Hamilton product r2 * r1, round to Q1.14, saturate.
  logic signed [63:0] hp_r [4][4];
  logic signed [65:0] s_r  [4];
  logic               deg_d;
  logic signed [67:0] qr_c [4];
  logic signed [QB-1:0] qs_c [4];
  qla_pkg::qla_out_t  out_r;

  qla_delay #(.W(1), .D(TD + 2 - (TA + 4))) u_deg_dly (
    .clk(clk), .en(adv), .d(deg4_r), .q(deg_d)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qr_c[i] = qla_pkg::rsh(68'(s_r[i]), 2 * WF - qla_pkg::QUAT_FRAC_BITS);
      if (qr_c[i] > qla_pkg::QUAT_LIM)       qs_c[i] = QB'(qla_pkg::QUAT_LIM);
      else if (qr_c[i] < -qla_pkg::QUAT_LIM) qs_c[i] = QB'(-qla_pkg::QUAT_LIM);
      else                                   qs_c[i] = QB'(qr_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          hp_r[i][j] <= $signed(r2_w[i]) * $signed(r1_d[j]);
        end
      end
      s_r[0] <= 66'(hp_r[0][0]) - 66'(hp_r[1][1]) - 66'(hp_r[2][2]) - 66'(hp_r[3][3]);
      s_r[1] <= 66'(hp_r[0][1]) + 66'(hp_r[1][0]) + 66'(hp_r[2][3]) - 66'(hp_r[3][2]);
      s_r[2] <= 66'(hp_r[0][2]) - 66'(hp_r[1][3]) + 66'(hp_r[2][0]) + 66'(hp_r[3][1]);
      s_r[3] <= 66'(hp_r[0][3]) + 66'(hp_r[1][2]) - 66'(hp_r[2][1]) + 66'(hp_r[3][0]);
      if (deg_d) begin
        out_r.quat_w     <= qla_pkg::QUAT_ONE;
        out_r.quat_x     <= '0;
        out_r.quat_y     <= '0;
        out_r.quat_z     <= '0;
        out_r.degenerate <= 1'b1;
      end else begin
        out_r.quat_w     <= qs_c[0];
        out_r.quat_x     <= qs_c[1];
        out_r.quat_y     <= qs_c[2];
        out_r.quat_z     <= qs_c[3];
        out_r.degenerate <= 1'b0;
      end
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// File: hdl/qla_checker.sv
// qla_checker: port-level checks for the look-at quaternion block, bound to the top level.
// Depends on qla_pkg.
`default_nettype none
module qla_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input qla_pkg::qla_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result beat changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.quat_w == qla_pkg::QUAT_ONE && out_data.quat_x == '0 &&
      out_data.quat_y == '0 && out_data.quat_z == '0)
    else $error("degenerate beat is not identity");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind quaternion_look_at_top qla_checker u_qla_checker (.*);
`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for quaternion_look_at_top; predicts every result in
// 64-bit integer math and scores it against the block. Depends on qla_pkg and the block.
`timescale 1ns / 100ps
module tb_top;

  localparam int     QB        = qla_pkg::QUAT_BITS;
  localparam int     QF        = qla_pkg::QUAT_FRAC_BITS;
  localparam longint ONE_Q30   = 64'sd1 <<< 30;
  localparam longint AXIS_MIN  = longint'((64'd1 << 60) / 100);
  localparam int     DRAIN_CYC = 400;
  localparam int     LIMIT_CYC = 400000;
  localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CMIN = 24'sh800000;

  typedef longint vec4_t [4];
  typedef struct {
    qla_pkg::qla_in_t data;
    bit               drain;  // wait for every pending result before offering this beat
  } pending_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  qla_pkg::qla_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  qla_pkg::qla_out_t out_data;

  pending_t          pending_beats[$];
  qla_pkg::qla_out_t expected_quats[$];
  int       n_fail = 0;
  int       n_sent = 0;
  int       cycle_cnt = 0;
  bit       in_took = 1'b0;
  bit       out_took = 1'b0;

  quaternion_look_at_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: fixed-point look-at quaternion, Q.30 working format
  // ---------------------------------------------------------------------------

  // Divide by 2^s, round half away from zero.
  function automatic longint round_shift(longint x, int s);
    longint unsigned m;
    m = (x < 0) ? longint'(-x) : x;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale to unit length in Q.30; a zero vector stays zero.
  function automatic void normalize(input vec4_t v, input int k, output vec4_t o);
    longint unsigned m [4];
    bit ng [4];
    longint unsigned mx, l2, len, r;
    mx = 0;
    l2 = 0;
    o = '{0, 0, 0, 0};
    for (int i = 0; i < k; i++) begin
      ng[i] = v[i] < 0;
      m[i] = ng[i] ? longint'(-v[i]) : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return;
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < k; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < k; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < k; i++) l2 += m[i] * m[i];
    len = int_sqrt(l2);
    for (int i = 0; i < k; i++) begin
      r = (m[i] * 64'd1073741824 + len / 2) / len;
      o[i] = ng[i] ? -longint'(r) : longint'(r);
    end
  endfunction

  // Shortest rotation taking a onto b; half turn when nearly opposite.
  function automatic void rotation_between(input vec4_t ar, input vec4_t br,
                                           output vec4_t q);
    vec4_t a, b, t, ax, axn;
    longint c;
    normalize(ar, 3, a);
    normalize(br, 3, b);
    c = round_shift(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], 30);
    if (c * 1000 < -999 * ONE_Q30) begin
      ax = '{-a[1], a[0], 0, 0};
      if (ax[0] * ax[0] + ax[1] * ax[1] < AXIS_MIN) ax = '{0, -a[2], a[1], 0};
      normalize(ax, 3, axn);
      q = '{0, axn[0], axn[1], axn[2]};
      return;
    end
    t[0] = ONE_Q30 + c;
    t[1] = round_shift(a[1] * b[2] - a[2] * b[1], 30);
    t[2] = round_shift(a[2] * b[0] - a[0] * b[2], 30);
    t[3] = round_shift(a[0] * b[1] - a[1] * b[0], 30);
    normalize(t, 4, q);
  endfunction

  function automatic qla_pkg::qla_out_t look_at_quat(qla_pkg::qla_in_t it);
    vec4_t d, u, n, v, rt, upp, nu, r1, r2, zf, s;
    longint lim, qv;
    bit flat;
    qla_pkg::qla_out_t res;
    lim = 64'sd1 <<< QF;
    d = '{it.dir_x, it.dir_y, it.dir_z, 0};
    u = '{it.up_x, it.up_y, it.up_z, 0};
    flat = d[1] * u[2] == d[2] * u[1] && d[2] * u[0] == d[0] * u[2] &&
           d[0] * u[1] == d[1] * u[0];
    if (!flat) begin
      normalize(d, 3, n);
      normalize(u, 3, v);
      rt[0] = round_shift(n[1] * v[2] - n[2] * v[1], 30);
      rt[1] = round_shift(n[2] * v[0] - n[0] * v[2], 30);
      rt[2] = round_shift(n[0] * v[1] - n[1] * v[0], 30);
      upp[0] = round_shift(rt[1] * n[2] - rt[2] * n[1], 30);
      upp[1] = round_shift(rt[2] * n[0] - rt[0] * n[2], 30);
      upp[2] = round_shift(rt[0] * n[1] - rt[1] * n[0], 30);
      upp[3] = 0;
      flat = upp[0] == 0 && upp[1] == 0 && upp[2] == 0;
    end
    res = '0;
    if (flat) begin
      res.quat_w = QB'(lim);
      res.degenerate = 1'b1;
      return res;
    end
    zf = '{0, 0, ONE_Q30, 0};
    rotation_between(zf, d, r1);
    nu[0] = round_shift(r1[1] * r1[2] - r1[0] * r1[3], 29);
    nu[1] = ONE_Q30 - round_shift(r1[1] * r1[1] + r1[3] * r1[3], 29);
    nu[2] = round_shift(r1[2] * r1[3] + r1[0] * r1[1], 29);
    nu[3] = 0;
    rotation_between(nu, upp, r2);
    s[0] = r2[0] * r1[0] - r2[1] * r1[1] - r2[2] * r1[2] - r2[3] * r1[3];
    s[1] = r2[0] * r1[1] + r2[1] * r1[0] + r2[2] * r1[3] - r2[3] * r1[2];
    s[2] = r2[0] * r1[2] - r2[1] * r1[3] + r2[2] * r1[0] + r2[3] * r1[1];
    s[3] = r2[0] * r1[3] + r2[1] * r1[2] - r2[2] * r1[1] + r2[3] * r1[0];
    for (int i = 0; i < 4; i++) begin
      qv = round_shift(s[i], 60 - QF);
      if (qv > lim) qv = lim;
      if (qv < -lim) qv = -lim;
      s[i] = qv;
    end
    res.quat_w = QB'(s[0]);
    res.quat_x = QB'(s[1]);
    res.quat_y = QB'(s[2]);
    res.quat_z = QB'(s[3]);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake sampling and scoring at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    qla_pkg::qla_out_t exp_q;
    cycle_cnt <= cycle_cnt + 1;
    in_took  <= rst_n && in_valid && !in_stall;
    out_took <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_quats.push_back(look_at_quat(in_data));
      n_sent <= n_sent + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_quats.size() == 0) begin
        $error("result beat with no expectation pending: %p", out_data);
        n_fail <= n_fail + 1;
      end else begin
        exp_q = expected_quats.pop_front();
        if (exp_q !== out_data) n_fail <= n_fail + 1;
        if (exp_q.quat_w !== out_data.quat_w)
          $error("quat_w expected %0d actual %0d", exp_q.quat_w, out_data.quat_w);
        if (exp_q.quat_x !== out_data.quat_x)
          $error("quat_x expected %0d actual %0d", exp_q.quat_x, out_data.quat_x);
        if (exp_q.quat_y !== out_data.quat_y)
          $error("quat_y expected %0d actual %0d", exp_q.quat_y, out_data.quat_y);
        if (exp_q.quat_z !== out_data.quat_z)
          $error("quat_z expected %0d actual %0d", exp_q.quat_z, out_data.quat_z);
        if (exp_q.degenerate !== out_data.degenerate)
          $error("degenerate expected %0d actual %0d",
                 exp_q.degenerate, out_data.degenerate);
      end
    end
    if (cycle_cnt > LIMIT_CYC) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: advance to the next pending beat after each accepted one
  // ---------------------------------------------------------------------------
  int  tx_gap = 0;
  bit  tx_burst = 1'b0;   // stretch with no idling between beats

  always @(negedge clk) begin
    pending_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold: the beat is still waiting for acceptance
    end else if (tx_gap > 0) begin
      tx_gap = tx_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_beats.size() == 0) begin
      in_valid <= 1'b0;
    end else if (pending_beats[0].drain && expected_quats.size() != 0) begin
      in_valid <= 1'b0;
    end else begin
      nxt = pending_beats.pop_front();
      in_data  <= nxt.data;
      in_valid <= 1'b1;
      if ($urandom_range(0, 99) == 0) tx_burst = !tx_burst;
      tx_gap = tx_burst ? 0 : $urandom_range(0, 9);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: may stall after each result; one long hold to back up the pipe
  // ---------------------------------------------------------------------------
  int rx_wait = 0;
  int rx_long = 0;
  bit rx_long_done = 1'b0;
  bit rx_burst = 1'b0;

  always @(negedge clk) begin
    if (out_took) begin
      if ($urandom_range(0, 99) == 0) rx_burst = !rx_burst;
      rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
    end
    if (!rx_long_done && n_sent >= 300) begin
      rx_long = 1000;
      rx_long_done = 1'b1;
    end
    if (rx_long > 0) begin
      rx_long = rx_long - 1;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic signed [23:0] rand_comp(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 2000)) - 1000);
      2: return 24'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom_range(0, 1) ? CMAX : CMIN;
    endcase
  endfunction

  task automatic add_beat(input int dx, dy, dz, ux, uy, uz, input int drain);
    pending_t p;
    p.data = '{24'(dx), 24'(dy), 24'(dz), 24'(ux), 24'(uy), 24'(uz)};
    p.drain = (drain != 0);
    pending_beats.push_back(p);
  endtask

  initial begin
    logic signed [23:0] dx, dy, dz, ux, uy, uz;
    int sc, mode;
    // directed: extremes, zero and parallel inputs, opposite vectors
    add_beat(0, 0, 1, 0, 1, 0, 0);                        // identity look
    add_beat(0, 0, 0, 0, 1, 0, 0);                        // zero direction
    add_beat(1, 2, 3, 0, 0, 0, 0);                        // zero up
    add_beat(0, 0, 0, 0, 0, 0, 0);
    add_beat(2, 4, 6, -1, -2, -3, 0);                     // exactly parallel
    add_beat(CMAX, CMAX - 1, 0, CMAX - 1, CMAX - 2, 0, 0); // parallel within precision
    add_beat(0, 0, -1, 0, 1, 0, 0);                       // direction along -Z
    add_beat(0, 0, -5, 1, 0, 0, 0);
    add_beat(1, 0, -CMAX, 0, 1, 0, 0);                    // nearly -Z
    add_beat(0, 0, 1, 0, -1, 0, 0);                       // up flips: half turn
    add_beat(0, 0, 1, 1, -CMAX, 0, 0);
    add_beat(CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, 0);
    add_beat(CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, 0);
    add_beat(CMIN, 0, 0, 0, CMIN, 0, 0);
    add_beat(CMAX, 0, 0, 0, 0, CMAX, 0);
    add_beat(0, CMAX, 0, 0, 0, 1, 0);
    add_beat(0, CMIN, 0, 1, 0, 0, 0);
    add_beat(-1, -1, -1, 1, -1, 0, 0);
    add_beat(1, 0, 0, 0, 1, 0, 0);
    add_beat(CMAX, 1, CMIN, -1, CMAX, 1, 0);
    add_beat(24'sh555555, 24'shAAAAAA, 24'sh0F0F0F, 24'shF0F0F0, 24'sh333333,
             24'shCCCCCC, 0);
    // random: mixed magnitudes, some near-degenerate pairs
    for (int i = 0; i < 1030; i++) begin
      mode = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) mode = $urandom_range(0, 2);
      dx = rand_comp(mode); dy = rand_comp(mode); dz = rand_comp(mode);
      ux = rand_comp(mode); uy = rand_comp(mode); uz = rand_comp(mode);
      case ($urandom_range(0, 11))
        0: begin                       // up parallel to direction, scaled
          sc = $urandom_range(1, 3);
          dx = 24'($signed($urandom_range(0, 4000)) - 2000);
          dy = 24'($signed($urandom_range(0, 4000)) - 2000);
          dz = 24'($signed($urandom_range(0, 4000)) - 2000);
          ux = 24'(dx * sc); uy = 24'(dy * sc); uz = 24'(dz * sc);
        end
        1: begin                       // up nearly parallel
          ux = dx; uy = dy; uz = dz + 24'($signed($urandom_range(0, 2)) - 1);
        end
        2: begin                       // direction close to -Z or +Z
          dx = 24'($signed($urandom_range(0, 4)) - 2);
          dy = 24'($signed($urandom_range(0, 4)) - 2);
          dz = $urandom_range(0, 1) ? CMIN + 24'($urandom_range(0, 99)) : CMAX;
        end
        3: begin                       // up nearly opposite the rotated +Y
          dx = '0; dy = '0; dz = 24'($urandom_range(1, 8388607));
          ux = 24'($signed($urandom_range(0, 4)) - 2);
          uy = -24'($urandom_range(1, 8388607));
          uz = 24'($signed($urandom_range(0, 4)) - 2);
        end
        default: ;
      endcase
      add_beat(dx, dy, dz, ux, uy, uz, (i == 500 || i == 900) ? 1 : 0);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_beats.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_fail == 0 && expected_quats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/qla_pkg.sv
hdl/qla_delay.sv
hdl/qla_unit.sv
hdl/quaternion_look_at_top.sv
hdl/qla_checker.sv
tb/sv/tb_top.sv
